// ===== sv/amrp_pkg.sv =====
// ----------------------------------------------------------------------------
// amrp_pkg: shared types and constants of the audio map record parser
// Holds the format codes, record phases, register indexes and the record
// layout used by the parser core, the output buffer and the top level.
// ----------------------------------------------------------------------------
package amrp_pkg;

    // Map formats held in the map_format register.
    localparam logic [2:0] FMT_FIVE  = 3'd0;
    localparam logic [2:0] FMT_SIX   = 3'd1;
    localparam logic [2:0] FMT_EIGHT = 3'd2;
    localparam logic [2:0] FMT_EARLY = 3'd3;
    localparam logic [2:0] FMT_LATE  = 3'd4;

    // Configuration register indexes (word address bits).
    localparam logic [1:0] REG_FORMAT   = 2'd0;
    localparam logic [1:0] REG_LENGTH   = 2'd1;
    localparam logic [1:0] REG_RESOURCE = 2'd2;

    localparam int unsigned PADDR_W = 4;

    // Record number that marks an entry to be dropped.
    localparam logic [15:0] DROP_NUMBER = 16'hffff;

    // Sequence flags: a sync word and a lip-sync word follow the delta.
    localparam int unsigned SEQ_SYNC_BIT = 31;
    localparam int unsigned SEQ_LIP_BIT  = 30;

    // Record phases.
    typedef enum logic [2:0] {
        PH_START  = 3'd0,
        PH_PREFIX = 3'd1,
        PH_BODY   = 3'd2,
        PH_SYNC   = 3'd3,
        PH_LIP    = 3'd4,
        PH_NEXT   = 3'd5
    } phase_t;

    // One decoded record, last field in the lowest bits.
    typedef struct packed {
        logic [15:0] entry_sync_size;
        logic [5:0]  entry_sequence;
        logic [7:0]  entry_condition;
        logic [7:0]  entry_verb;
        logic [7:0]  entry_noun;
        logic [31:0] entry_offset;
        logic [15:0] entry_number;
    } record_t;

    localparam int unsigned RECORD_W = $bits(record_t);
    localparam int unsigned TDATA_W  = ((RECORD_W + 7) / 8) * 8;

    // Status of the parser core, watched by the top level.
    typedef struct packed {
        phase_t phase;
        logic   stopped;
    } core_status_t;

    // Status of the output buffer.
    typedef struct packed {
        logic out_valid;
        logic skid_valid;
    } obuf_status_t;

    // Nominal record size of each format; a record starts only while more
    // bytes than this remain.
    function automatic logic [4:0] nominal_size(input logic [2:0] fmt);
        logic [4:0] size;
        begin
            case (fmt)
                FMT_FIVE:  size = 5'd5;
                FMT_SIX:   size = 5'd6;
                FMT_EIGHT: size = 5'd8;
                FMT_EARLY: size = 5'd10;
                default:   size = 5'd11;
            endcase
            return size;
        end
    endfunction

endpackage

// ===== sv/amrp_core.sv =====
// ----------------------------------------------------------------------------
// amrp_core: byte-at-a-time map parser
// Holds the field counter, assembly word and accumulators, and decodes one
// stream byte per accepted item into the next state and at most one record.
// ----------------------------------------------------------------------------
module amrp_core
    import amrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         take,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic [2:0]   map_format,
    input  logic [23:0]  map_length,
    input  logic [15:0]  resource_number,
    output logic         rec_valid,
    output record_t      rec,
    output core_status_t status
);

    logic [23:0] consumed_reg;
    logic [3:0]  fpos_reg;
    phase_t      phase_reg;
    logic [31:0] offset_reg;
    logic [31:0] asm_reg;
    logic [15:0] number_reg;
    logic [31:0] msg_reg;
    logic [15:0] sync_reg;
    logic        stopped_reg;

    logic [23:0] consumed_next;
    logic [3:0]  fpos_next;
    phase_t      phase_next;
    logic [31:0] offset_next;
    logic [31:0] asm_next;
    logic [15:0] number_next;
    logic [31:0] msg_next;
    logic [15:0] sync_next;
    logic        stopped_next;

    logic        length_spent;

    // No record may start once the bytes left no longer exceed the record size.
    assign length_spent = ({1'b0, map_length}) <=
                          ({1'b0, consumed_reg} + {20'd0, nominal_size(map_format)});

    // Decode of one byte.
    always_comb
    begin
        logic        go;
        logic        emit;
        logic        sync_map;
        logic [3:0]  p;
        logic [15:0] emit_number;
        logic [31:0] emit_offset;
        begin
            consumed_next = consumed_reg;
            fpos_next     = fpos_reg;
            phase_next    = phase_reg;
            offset_next   = offset_reg;
            asm_next      = asm_reg;
            number_next   = number_reg;
            msg_next      = msg_reg;
            sync_next     = sync_reg;
            stopped_next  = stopped_reg;
            go            = 1'b0;
            emit          = 1'b0;
            sync_map      = 1'b0;
            p             = fpos_reg;
            emit_number   = number_reg;
            emit_offset   = offset_reg;
            rec_valid     = 1'b0;
            rec           = '0;

            if (take && (map_format <= FMT_LATE) && !stopped_reg)
            begin
                go = 1'b1;
                if ((phase_reg == PH_START) && (map_format == FMT_LATE))
                begin
                    phase_next = PH_PREFIX;
                    fpos_next  = 4'd0;
                end
                if ((phase_next == PH_START) || (phase_next == PH_NEXT))
                begin
                    if (length_spent)
                    begin
                        stopped_next = 1'b1;
                        go           = 1'b0;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                        fpos_next  = 4'd0;
                    end
                end

                if (go)
                begin
                    asm_next  = {data_byte, asm_reg[31:8]};
                    p         = fpos_next;
                    fpos_next = p + 4'd1;

                    case (phase_next)
                        PH_PREFIX:
                        begin
                            if (p >= 4'd3)
                            begin
                                offset_next = asm_next;
                                phase_next  = PH_NEXT;
                                fpos_next   = 4'd0;
                            end
                        end
                        PH_SYNC:
                        begin
                            if (p >= 4'd1)
                            begin
                                sync_next = asm_next[31:16];
                                if (msg_reg[SEQ_LIP_BIT])
                                begin
                                    phase_next = PH_LIP;
                                    fpos_next  = 4'd0;
                                end
                                else
                                begin
                                    emit        = 1'b1;
                                    sync_map    = 1'b1;
                                    emit_number = resource_number;
                                end
                            end
                        end
                        PH_LIP:
                        begin
                            if (p >= 4'd1)
                            begin
                                sync_next   = sync_reg + asm_next[31:16];
                                emit        = 1'b1;
                                sync_map    = 1'b1;
                                emit_number = resource_number;
                            end
                        end
                        default:
                        begin
                            if ((map_format <= FMT_EIGHT) && (p == 4'd1))
                            begin
                                number_next = asm_next[31:16];
                            end
                            emit_number = number_next;
                            case (map_format)
                                FMT_FIVE:
                                begin
                                    if (p >= 4'd4)
                                    begin
                                        offset_next = offset_reg + {8'd0, asm_next[31:8]};
                                        emit_offset = offset_next;
                                        emit        = 1'b1;
                                    end
                                end
                                FMT_SIX:
                                begin
                                    // The absolute offset goes out as it is and
                                    // leaves the running offset alone.
                                    if (p >= 4'd5)
                                    begin
                                        emit_offset = asm_next;
                                        emit        = 1'b1;
                                    end
                                end
                                FMT_EIGHT:
                                begin
                                    if (p >= 4'd7)
                                    begin
                                        emit_offset = asm_next;
                                        emit        = 1'b1;
                                    end
                                end
                                FMT_EARLY:
                                begin
                                    if (p == 4'd3)
                                    begin
                                        msg_next = asm_next;
                                    end
                                    if (p == 4'd7)
                                    begin
                                        offset_next = asm_next;
                                    end
                                    if (p >= 4'd9)
                                    begin
                                        emit        = 1'b1;
                                        sync_map    = 1'b1;
                                        emit_number = resource_number;
                                    end
                                end
                                default:
                                begin
                                    if (p == 4'd3)
                                    begin
                                        msg_next = asm_next;
                                    end
                                    if (p >= 4'd6)
                                    begin
                                        offset_next = offset_reg + {8'd0, asm_next[31:8]};
                                        emit_offset = offset_next;
                                        sync_next   = 16'd0;
                                        fpos_next   = 4'd0;
                                        if (msg_next[SEQ_SYNC_BIT])
                                        begin
                                            phase_next = PH_SYNC;
                                        end
                                        else if (msg_next[SEQ_LIP_BIT])
                                        begin
                                            phase_next = PH_LIP;
                                        end
                                        else
                                        begin
                                            emit        = 1'b1;
                                            sync_map    = 1'b1;
                                            emit_number = resource_number;
                                        end
                                    end
                                end
                            endcase
                        end
                    endcase
                end
            end

            // A completed entry closes the record; the drop number is swallowed.
            if (emit)
            begin
                phase_next = PH_NEXT;
                fpos_next  = 4'd0;
                rec_valid  = (emit_number != DROP_NUMBER);
                rec.entry_number = emit_number;
                rec.entry_offset = emit_offset;
                if (sync_map)
                begin
                    rec.entry_noun      = msg_next[7:0];
                    rec.entry_verb      = msg_next[15:8];
                    rec.entry_condition = msg_next[23:16];
                    rec.entry_sequence  = msg_next[29:24];
                    if ((phase_reg == PH_BODY || phase_reg == PH_NEXT || phase_reg == PH_START)
                        && map_format == FMT_EARLY)
                    begin
                        // Early sync carries the sync word in the last two bytes.
                        rec.entry_sync_size = asm_next[31:16];
                    end
                    else
                    begin
                        rec.entry_sync_size = sync_next;
                    end
                end
            end

            if (take)
            begin
                if (consumed_reg != 24'hffffff)
                begin
                    consumed_next = consumed_reg + 24'd1;
                end
                if (last_byte)
                begin
                    consumed_next = 24'd0;
                    fpos_next     = 4'd0;
                    phase_next    = PH_START;
                    offset_next   = 32'd0;
                    asm_next      = 32'd0;
                    number_next   = 16'd0;
                    msg_next      = 32'd0;
                    sync_next     = 16'd0;
                    stopped_next  = 1'b0;
                end
            end
        end
    end

    // Parser state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            consumed_reg <= 24'd0;
            fpos_reg     <= 4'd0;
            phase_reg    <= PH_START;
            offset_reg   <= 32'd0;
            asm_reg      <= 32'd0;
            number_reg   <= 16'd0;
            msg_reg      <= 32'd0;
            sync_reg     <= 16'd0;
            stopped_reg  <= 1'b0;
        end
        else
        begin
            consumed_reg <= consumed_next;
            fpos_reg     <= fpos_next;
            phase_reg    <= phase_next;
            offset_reg   <= offset_next;
            asm_reg      <= asm_next;
            number_reg   <= number_next;
            msg_reg      <= msg_next;
            sync_reg     <= sync_next;
            stopped_reg  <= stopped_next;
        end
    end

    assign status.phase   = phase_reg;
    assign status.stopped = stopped_reg;

endmodule

// ===== sv/amrp_obuf.sv =====
// ----------------------------------------------------------------------------
// amrp_obuf: two-place output register for decoded records
// An output register with a skid stage behind it, so the parser keeps
// taking bytes while a finished record waits to be taken.
// ----------------------------------------------------------------------------
module amrp_obuf
    import amrp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  record_t      push_rec,
    output logic         can_take,
    output logic         out_valid,
    input  logic         out_ready,
    output record_t      out_rec,
    output obuf_status_t status
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    record_t out_rec_reg;
    record_t skid_rec_reg;

    logic    out_valid_next;
    logic    skid_valid_next;
    record_t out_rec_next;
    record_t skid_rec_next;

    // Refill the output register from the skid stage first, then from the core.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_rec_next    = out_rec_reg;
        skid_rec_next   = skid_rec_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_rec_next    = skid_rec_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = push;
                skid_rec_next   = push_rec;
            end
            else
            begin
                out_rec_next   = push_rec;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_rec_next   = push_rec;
            skid_valid_next = 1'b1;
        end
    end

    // Control flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Record payload.
    always_ff @(posedge clk)
    begin
        out_rec_reg  <= out_rec_next;
        skid_rec_reg <= skid_rec_next;
    end

    assign can_take          = !skid_valid_reg;
    assign out_valid         = out_valid_reg;
    assign out_rec           = out_rec_reg;
    assign status.out_valid  = out_valid_reg;
    assign status.skid_valid = skid_valid_reg;

endmodule

// ===== sv/audio_map_record_parser_top.sv =====
// ----------------------------------------------------------------------------
// audio_map_record_parser_top: audio map record parser
// Decodes a little-endian audio map byte stream into one record per entry,
// with the map format, map length and resource number set over APB.
// ----------------------------------------------------------------------------
// The block takes one map byte in every cycle in which s_axis_tready is high
// and registers the record it completes, into the skid stage if the output
// stalls; each byte is decoded in one pass through the field counter and
// offset adder. Two record places (output register and skid stage) keep
// s_axis_tready high while one record waits; it drops only when both are
// full. The user writes configuration with the stream idle; not enforced.
module audio_map_record_parser_top
    import amrp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // Map byte stream
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,  // [7:0] data_byte
    input  logic                s_axis_tlast,  // last_byte
    // Decoded records
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [15:0] entry_number, [47:16] entry_offset, [55:48] entry_noun,
    // [63:56] entry_verb, [71:64] entry_condition, [77:72] entry_sequence,
    // [93:78] entry_sync_size, [95:94] zero
    output logic [TDATA_W-1:0]  m_axis_tdata
);

    logic [2:0]   format_reg;
    logic [23:0]  length_reg;
    logic [15:0]  resource_reg;

    logic         cfg_write;
    logic         take;
    logic         rec_valid;
    record_t      rec;
    record_t      out_rec;
    logic         can_take;
    core_status_t core_status;
    obuf_status_t obuf_status;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg   <= FMT_FIVE;
            length_reg   <= 24'd0;
            resource_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FORMAT:   format_reg   <= pwdata[2:0];
                REG_LENGTH:   length_reg   <= pwdata[23:0];
                REG_RESOURCE: resource_reg <= pwdata[15:0];
                default:      ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_FORMAT:   prdata = {29'd0, format_reg};
            REG_LENGTH:   prdata = {8'd0, length_reg};
            REG_RESOURCE: prdata = {16'd0, resource_reg};
            default:      prdata = 32'd0;
        endcase
    end

    assign s_axis_tready = can_take;
    assign take          = s_axis_tvalid && can_take;

    amrp_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .take            (take),
        .data_byte       (s_axis_tdata),
        .last_byte       (s_axis_tlast),
        .map_format      (format_reg),
        .map_length      (length_reg),
        .resource_number (resource_reg),
        .rec_valid       (rec_valid),
        .rec             (rec),
        .status          (core_status)
    );

    amrp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_valid),
        .push_rec  (rec),
        .can_take  (can_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec),
        .status    (obuf_status)
    );

    assign m_axis_tdata = {{(TDATA_W - RECORD_W){1'b0}}, out_rec};

    // The skid stage is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_status.skid_valid |-> obuf_status.out_valid)
        else $error("skid stage holds a record while the output is empty");

    // A record made while the output is stalled lands in the skid stage.
    a_push_into_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && obuf_status.out_valid && !m_axis_tready) |=> obuf_status.skid_valid)
        else $error("record lost while the output was stalled");

    // The last byte of a stream returns the parser to its start.
    a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (take && s_axis_tlast) |=> (core_status.phase == PH_START && !core_status.stopped))
        else $error("parser did not restart after the last byte");

    // Unknown formats never produce a record.
    a_unknown_format: assert property (@(posedge clk) disable iff (!rst_n)
        (format_reg > FMT_LATE) |-> !rec_valid)
        else $error("record made under an unknown format");

endmodule
